// ----- src/nsp_pkg.sv -----
`default_nettype none
package nsp_pkg;

   localparam int COORD_BITS  = 28;
   localparam int T_FRAC_BITS = 20;
   localparam int RADIUS_W    = 24;
   localparam int ID_W        = 32;
   localparam int DIST_W      = 48;
   localparam int SQ_IN_W     = 24;

   // Coordinate differences, projection parameter and serial multiplier operands.
   localparam int DIFF_W   = COORD_BITS + 1;
   localparam int T_W      = T_FRAC_BITS + 1;
   localparam int OP_W     = (DIFF_W > T_W) ? DIFF_W : T_W;
   localparam int PROD_W   = 2 * OP_W;
   localparam int DOT_W    = PROD_W + 2;
   localparam int DX_W     = DIFF_W + 2;
   localparam int MUL_CNT_W = $clog2(OP_W);
   localparam int DIV_CNT_W = (T_FRAC_BITS > 1) ? $clog2(T_FRAC_BITS) : 1;

   localparam logic [ID_W-1:0] MISS_ID = '1;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] query_x;
      logic signed [COORD_BITS-1:0] query_y;
      logic [RADIUS_W-1:0]          search_radius;
      logic signed [COORD_BITS-1:0] start_x;
      logic signed [COORD_BITS-1:0] start_y;
      logic signed [COORD_BITS-1:0] end_x;
      logic signed [COORD_BITS-1:0] end_y;
      logic [ID_W-1:0]              seg_id;
      logic                         endpoints_valid;
      logic                         first_of_query;
      logic                         last_of_query;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] best_seg_id;
      logic            hit;
   } rsp_type;

   function automatic logic [DIFF_W-1:0] mag_diff(input logic [DIFF_W-1:0] v);
      return v[DIFF_W-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic [DX_W-1:0] mag_dx(input logic [DX_W-1:0] v);
      return v[DX_W-1] ? (~v + 1'b1) : v;
   endfunction

endpackage
`default_nettype wire

// ----- src/nsp_mul_serial.sv -----
`default_nettype none
// Shift-and-add multiplier, one multiplier bit per cycle.
module nsp_mul_serial
   import nsp_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [OP_W-1:0]   mcand,
   input  wire logic [OP_W-1:0]   mplier,
   output logic                   done,
   output logic [PROD_W-1:0]      product
);

   logic [PROD_W-1:0]    mcand_ff, mcand_in;
   logic [OP_W-1:0]      mplier_ff, mplier_in;
   logic [PROD_W-1:0]    acc_ff, acc_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   always_comb begin
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (start) begin
         mcand_in  = PROD_W'(mcand);
         mplier_in = mplier;
         acc_in    = '0;
         cnt_in    = '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[PROD_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[OP_W-1:1]};
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == MUL_CNT_W'(OP_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

// ----- src/nearest_segment_pick_unit.sv -----
`default_nettype none
// Channel   Direction  Payload    Handshake
// req_      in         req_type   req_valid / req_ready, one candidate segment a beat
// rsp_      out        rsp_type   rsp_valid / rsp_ready, one pick result a beat
//
// A valid segment makes three passes through the bit-serial multipliers and one
// restoring division. The division is skipped when the parameter clamps or the
// segment has zero length. A segment without valid endpoints goes from idle
// straight to the emit state.
// Reset is synchronous and clears the control state and the running best.
// A new beat is taken only when the previous segment has finished. A result waits in
// the output register; the block stalls at the end of a last segment only while an
// earlier result has not yet been taken.
module nearest_segment_pick_unit
   import nsp_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_M1   = 4'd1;
   localparam logic [3:0] ST_W1   = 4'd2;
   localparam logic [3:0] ST_SUM  = 4'd3;
   localparam logic [3:0] ST_DIV  = 4'd4;
   localparam logic [3:0] ST_M2   = 4'd5;
   localparam logic [3:0] ST_W2   = 4'd6;
   localparam logic [3:0] ST_OFFS = 4'd7;
   localparam logic [3:0] ST_M3   = 4'd8;
   localparam logic [3:0] ST_W3   = 4'd9;
   localparam logic [3:0] ST_CMP  = 4'd10;
   localparam logic [3:0] ST_EMIT = 4'd11;

   logic [3:0] state_ff, state_in;

   // Running best of the current query.
   logic [DIST_W-1:0] best_ff, best_in;
   logic [ID_W-1:0]   best_id_ff, best_id_in;
   logic              found_ff, found_in;

   // Per-segment working registers.
   logic [DIFF_W-1:0] abx_ff, aby_ff, apx_ff, apy_ff;
   logic [DIFF_W-1:0] abx_in, aby_in, apx_in, apy_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic              last_ff, last_in;
   logic [PROD_W-1:0] len_ff, len_in;
   logic [DOT_W-1:0]  dot_ff, dot_in;
   logic [PROD_W-1:0] rem_ff, rem_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic [DIV_CNT_W-1:0] dcnt_ff, dcnt_in;
   logic [DX_W-1:0]   dxm_ff, dym_ff, dxm_in, dym_in;
   logic              capx_ff, capy_ff, capx_in, capy_in;

   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;

   // Four serial multipliers; all four run in every pass, the later passes use two products.
   logic [OP_W-1:0]   mcand [4];
   logic [OP_W-1:0]   mplier [4];
   logic [PROD_W-1:0] prod [4];
   logic [3:0]        mul_done;
   logic              mul_start;

   for (genvar g = 0; g < 4; g++) begin : g_mul
      nsp_mul_serial u_mul (
         .clock   (clock),
         .reset   (reset),
         .start   (mul_start),
         .mcand   (mcand[g]),
         .mplier  (mplier[g]),
         .done    (mul_done[g]),
         .product (prod[g])
      );
   end

   assign mul_start = (state_ff == ST_M1) || (state_ff == ST_M2) || (state_ff == ST_M3);

   always_comb begin
      mcand[0]  = OP_W'(mag_diff(abx_ff));
      mcand[1]  = OP_W'(mag_diff(aby_ff));
      mcand[2]  = OP_W'(mag_diff(abx_ff));
      mcand[3]  = OP_W'(mag_diff(aby_ff));
      mplier[0] = OP_W'(mag_diff(abx_ff));
      mplier[1] = OP_W'(mag_diff(aby_ff));
      mplier[2] = OP_W'(mag_diff(apx_ff));
      mplier[3] = OP_W'(mag_diff(apy_ff));
      if (state_ff == ST_M2) begin
         mplier[0] = OP_W'(t_ff);
         mplier[1] = OP_W'(t_ff);
      end else if (state_ff == ST_M3) begin
         mcand[0]  = OP_W'(dxm_ff);
         mcand[1]  = OP_W'(dym_ff);
         mplier[0] = OP_W'(dxm_ff);
         mplier[1] = OP_W'(dym_ff);
      end
   end

   // Combinational helpers for the arithmetic steps.
   logic [DOT_W-1:0]    term2, term3;
   logic                dot_le_zero, dot_ge_len;
   logic [PROD_W:0]     div_sh;
   logic                div_ge;
   logic [PROD_W:0]     rnd_x, rnd_y;
   logic [DX_W-1:0]     offs_x, offs_y, dx, dy, dxm, dym;
   logic [DIST_W:0]     sq_x, sq_y;
   logic [DIST_W+1:0]   dist_sum;
   logic [2*RADIUS_W-1:0] rad_sq;

   always_comb begin
      term2 = (apx_ff[DIFF_W-1] ^ abx_ff[DIFF_W-1]) ? (DOT_W'(0) - DOT_W'(prod[2]))
                                                    : DOT_W'(prod[2]);
      term3 = (apy_ff[DIFF_W-1] ^ aby_ff[DIFF_W-1]) ? (DOT_W'(0) - DOT_W'(prod[3]))
                                                    : DOT_W'(prod[3]);
      dot_le_zero = dot_ff[DOT_W-1] || (dot_ff == '0);
      dot_ge_len  = ($signed(dot_ff) >= $signed(DOT_W'(len_ff)));

      div_sh = {rem_ff, 1'b0};
      div_ge = (div_sh >= (PROD_W+1)'(len_ff));

      // Offset along the segment, rounded half away from zero on the magnitude.
      rnd_x  = (PROD_W+1)'(prod[0]) + ((PROD_W+1)'(1) << (T_FRAC_BITS - 1));
      rnd_y  = (PROD_W+1)'(prod[1]) + ((PROD_W+1)'(1) << (T_FRAC_BITS - 1));
      offs_x = DX_W'(rnd_x >> T_FRAC_BITS);
      offs_y = DX_W'(rnd_y >> T_FRAC_BITS);
      dx = {{2{apx_ff[DIFF_W-1]}}, apx_ff}
           - (abx_ff[DIFF_W-1] ? (DX_W'(0) - offs_x) : offs_x);
      dy = {{2{apy_ff[DIFF_W-1]}}, apy_ff}
           - (aby_ff[DIFF_W-1] ? (DX_W'(0) - offs_y) : offs_y);
      dxm = mag_dx(dx);
      dym = mag_dx(dy);

      // A component of 2^24 or more squares to at least 2^48, which never wins.
      sq_x = capx_ff ? ((DIST_W+1)'(1) << DIST_W) : (DIST_W+1)'(prod[0][DIST_W-1:0]);
      sq_y = capy_ff ? ((DIST_W+1)'(1) << DIST_W) : (DIST_W+1)'(prod[1][DIST_W-1:0]);
      dist_sum = (DIST_W+2)'(sq_x) + (DIST_W+2)'(sq_y);

      rad_sq = req_data.search_radius * req_data.search_radius;
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      best_in      = best_ff;
      best_id_in   = best_id_ff;
      found_in     = found_ff;
      abx_in       = abx_ff;
      aby_in       = aby_ff;
      apx_in       = apx_ff;
      apy_in       = apy_ff;
      id_in        = id_ff;
      last_in      = last_ff;
      len_in       = len_ff;
      dot_in       = dot_ff;
      rem_in       = rem_ff;
      t_in         = t_ff;
      dcnt_in      = dcnt_ff;
      dxm_in       = dxm_ff;
      dym_in       = dym_ff;
      capx_in      = capx_ff;
      capy_in      = capy_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.first_of_query) begin
                  best_in    = DIST_W'(rad_sq);
                  best_id_in = MISS_ID;
                  found_in   = 1'b0;
               end
               abx_in  = {req_data.end_x[COORD_BITS-1], req_data.end_x}
                         - {req_data.start_x[COORD_BITS-1], req_data.start_x};
               aby_in  = {req_data.end_y[COORD_BITS-1], req_data.end_y}
                         - {req_data.start_y[COORD_BITS-1], req_data.start_y};
               apx_in  = {req_data.query_x[COORD_BITS-1], req_data.query_x}
                         - {req_data.start_x[COORD_BITS-1], req_data.start_x};
               apy_in  = {req_data.query_y[COORD_BITS-1], req_data.query_y}
                         - {req_data.start_y[COORD_BITS-1], req_data.start_y};
               id_in   = req_data.seg_id;
               last_in = req_data.last_of_query;
               state_in = req_data.endpoints_valid ? ST_M1 : ST_EMIT;
            end
         end
         ST_M1: state_in = ST_W1;
         ST_W1: begin
            if (mul_done[0]) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // Registers are loaded with len and dot in ST_W1's last cycle below.
            dcnt_in = '0;
            rem_in  = dot_ff[PROD_W-1:0];
            if ((len_ff == '0) || dot_le_zero) begin
               t_in     = '0;
               state_in = ST_M2;
            end else if (dot_ge_len) begin
               t_in     = T_W'(1) << T_FRAC_BITS;
               state_in = ST_M2;
            end else begin
               t_in     = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in  = div_ge ? PROD_W'(div_sh - (PROD_W+1)'(len_ff)) : PROD_W'(div_sh);
            t_in    = {t_ff[T_W-2:0], div_ge};
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DIV_CNT_W'(T_FRAC_BITS - 1)) begin
               state_in = ST_M2;
            end
         end
         ST_M2: state_in = ST_W2;
         ST_W2: begin
            if (mul_done[0]) begin
               state_in = ST_OFFS;
            end
         end
         ST_OFFS: begin
            dxm_in   = dxm;
            dym_in   = dym;
            capx_in  = (64'(dxm) >= (64'(1) << SQ_IN_W));
            capy_in  = (64'(dym) >= (64'(1) << SQ_IN_W));
            state_in = ST_M3;
         end
         ST_M3: state_in = ST_W3;
         ST_W3: begin
            if (mul_done[0]) begin
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            if (dist_sum < (DIST_W+2)'(best_ff)) begin
               best_in    = dist_sum[DIST_W-1:0];
               best_id_in = id_ff;
               found_in   = 1'b1;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (!last_ff) begin
               state_in = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.best_seg_id = best_id_ff;
               rsp_in.hit         = found_ff;
               rsp_valid_in       = 1'b1;
               best_in            = '0;
               best_id_in         = MISS_ID;
               found_in           = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // The first-pass products are taken as they finish.
      if ((state_ff == ST_W1) && mul_done[0]) begin
         len_in = prod[0] + prod[1];
         dot_in = term2 + term3;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         best_ff      <= '0;
         best_id_ff   <= MISS_ID;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         best_ff      <= best_in;
         best_id_ff   <= best_id_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
         dcnt_ff      <= dcnt_in;
      end
      abx_ff  <= abx_in;
      aby_ff  <= aby_in;
      apx_ff  <= apx_in;
      apy_ff  <= apy_in;
      id_ff   <= id_in;
      last_ff <= last_in;
      len_ff  <= len_in;
      dot_ff  <= dot_in;
      rem_ff  <= rem_in;
      t_ff    <= t_in;
      dxm_ff  <= dxm_in;
      dym_ff  <= dym_in;
      capx_ff <= capx_in;
      capy_ff <= capy_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   // A miss always reports the all-ones id.
   a_miss_id: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.hit) |-> (rsp_data.best_seg_id == MISS_ID))
      else $error("miss result without all-ones id");

   // The divider leaves only toward the offset multiply.
   a_div_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |=> ((state_ff == ST_DIV) || (state_ff == ST_M2)))
      else $error("divider left early");

   // Emitting a result clears the running query.
   a_emit_clear: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_EMIT) && last_ff && (!rsp_valid_ff || rsp_ready))
      |=> (!found_ff && rsp_valid_ff))
      else $error("query state not cleared after result");
`endif

endmodule
`default_nettype wire
